// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file i2p_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, idle while reset is low
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, idle while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/i2p_pkg.sv =====
`default_nettype none

package i2p_pkg;

    // operator stack geometry
    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CHAR_W      = 8;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;

    // error codes on the result channel
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNMATCHED = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

    // command kinds handed from front to back
    typedef logic [2:0] t_kind;
    localparam t_kind K_ALNUM = 3'd0;
    localparam t_kind K_OPEN  = 3'd1;
    localparam t_kind K_CLOSE = 3'd2;
    localparam t_kind K_OPER  = 3'd3;
    localparam t_kind K_END   = 3'd4;

    typedef logic [2:0] t_prio;
    localparam t_prio PRIO_NONE   = 3'd0;
    localparam t_prio PRIO_ADD    = 3'd1;
    localparam t_prio PRIO_MUL    = 3'd2;
    localparam t_prio PRIO_POW_ST = 3'd3;
    localparam t_prio PRIO_POW_IN = 3'd4;

    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] ch;
        t_prio             prio;
    } t_cmd;

    // priority of a character arriving from the input
    function automatic t_prio prio_incoming(input logic [CHAR_W-1:0] c);
        t_prio p;
        case (c)
            CH_PLUS, CH_MINUS: p = PRIO_ADD;
            CH_STAR, CH_SLASH: p = PRIO_MUL;
            CH_CARET:          p = PRIO_POW_IN;
            default:           p = PRIO_NONE;
        endcase
        return p;
    endfunction

    // priority of a character sitting on the stack
    function automatic t_prio prio_stacked(input logic [CHAR_W-1:0] c);
        t_prio p;
        case (c)
            CH_PLUS, CH_MINUS: p = PRIO_ADD;
            CH_STAR, CH_SLASH: p = PRIO_MUL;
            CH_CARET:          p = PRIO_POW_ST;
            default:           p = PRIO_NONE;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/i2p_if.sv =====
`default_nettype none

// input character channel
interface i2p_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_expr;

    modport source (output valid, output in_char, output end_of_expr, input ready);
    modport sink   (input valid, input in_char, input end_of_expr, output ready);
endinterface

// postfix result channel
interface i2p_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       is_last;
    logic [1:0] err_code;

    modport source (output valid, output out_char, output is_last, output err_code,
                    input ready);
    modport sink   (input valid, input out_char, input is_last, input err_code,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/i2p_ram.sv =====
`default_nettype none

module i2p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/i2p_front.sv =====
`default_nettype none

module i2p_front
    import i2p_pkg::*;
(
    i2p_in_if.sink     i_in,
    output t_cmd       o_cmd,
    output logic       o_cmd_valid,
    input  wire logic  i_cmd_ready
);

    localparam logic [CHAR_W-1:0] CH_DIG_LO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIG_HI = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPP_LO = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPP_HI = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOW_LO = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_HI = 8'h7A;

    logic is_alnum;

    // ascii letters and digits only
    assign is_alnum = (i_in.in_char >= CH_DIG_LO && i_in.in_char <= CH_DIG_HI) ||
                      (i_in.in_char >= CH_UPP_LO && i_in.in_char <= CH_UPP_HI) ||
                      (i_in.in_char >= CH_LOW_LO && i_in.in_char <= CH_LOW_HI);

    // classify the beat into a command for the back end
    always_comb begin
        o_cmd.ch   = i_in.in_char;
        o_cmd.prio = prio_incoming(i_in.in_char);
        if (i_in.end_of_expr) begin
            o_cmd.kind = K_END;
        end else if (is_alnum) begin
            o_cmd.kind = K_ALNUM;
        end else if (i_in.in_char == CH_LPAREN) begin
            o_cmd.kind = K_OPEN;
        end else if (i_in.in_char == CH_RPAREN) begin
            o_cmd.kind = K_CLOSE;
        end else begin
            o_cmd.kind = K_OPER;
        end
    end

    assign o_cmd_valid = i_in.valid;
    assign i_in.ready  = i_cmd_ready;

endmodule

`default_nettype wire

// ===== rtl/i2p_cmd_queue.sv =====
`default_nettype none

module i2p_cmd_queue
    import i2p_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cmd  i_cmd,
    input  wire logic  i_valid,
    output logic       o_ready,
    output t_cmd       o_cmd,
    output logic       o_valid,
    input  wire logic  i_ready
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = i_ready && o_valid;

    // two-entry command fifo
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // payload storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/i2p_back.sv =====
`default_nettype none

module i2p_back
    import i2p_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cmd  i_cmd,
    input  wire logic  i_cmd_valid,
    output logic       o_cmd_ready,
    i2p_out_if.source  o_out
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_TEST  = 2'd2;
    localparam logic [1:0] ST_PUSH  = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    t_cmd              r_cmd;
    t_cmd              n_cmd;

    logic              r_o_valid;
    logic [CHAR_W-1:0] r_o_char;
    logic              r_o_last;
    logic [1:0]        r_o_err;

    logic              slot_free;
    logic              e_valid;
    logic [CHAR_W-1:0] e_char;
    logic              e_last;
    logic [1:0]        e_err;
    logic              e_fire;

    logic              ram_we;
    logic [ADDR_W-1:0] top_ptr;
    logic [CHAR_W-1:0] top_char;

    assign slot_free = !r_o_valid || o_out.ready;
    assign e_fire    = e_valid && slot_free;
    assign top_ptr   = r_count[ADDR_W-1:0] - ADDR_W'(1);

    // operator stack, read address always points at the top entry
    i2p_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (r_cmd.ch),
        .i_raddr (top_ptr),
        .o_rdata (top_char)
    );

    // sequencer: one stack step per pass, stalls on a beat to emit while the result slot is full
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cmd       = r_cmd;
        o_cmd_ready = 1'b0;
        ram_we      = 1'b0;
        e_valid     = 1'b0;
        e_char      = CH_NUL;
        e_last      = 1'b0;
        e_err       = ERR_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.kind == K_ALNUM) begin
                        e_valid     = 1'b1;
                        e_char      = i_cmd.ch;
                        o_cmd_ready = slot_free;
                    end else begin
                        o_cmd_ready = 1'b1;
                        n_cmd       = i_cmd;
                        n_state     = (i_cmd.kind == K_OPEN) ? ST_PUSH : ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                if (r_count == '0) begin
                    unique case (r_cmd.kind)
                        K_CLOSE: begin
                            e_valid = 1'b1;
                            e_err   = ERR_UNMATCHED;
                            if (slot_free) begin
                                n_state = ST_IDLE;
                            end
                        end
                        K_END: begin
                            e_valid = 1'b1;
                            e_last  = 1'b1;
                            if (slot_free) begin
                                n_state = ST_IDLE;
                            end
                        end
                        default: begin
                            n_state = ST_PUSH;
                        end
                    endcase
                end else begin
                    n_state = ST_TEST;
                end
            end
            ST_TEST: begin
                if (r_cmd.kind == K_CLOSE && top_char == CH_LPAREN) begin
                    // matching open paren is dropped
                    n_count = r_count - CNT_W'(1);
                    n_state = ST_IDLE;
                end else if (r_cmd.kind == K_OPER &&
                             prio_stacked(top_char) < r_cmd.prio) begin
                    n_state = ST_PUSH;
                end else begin
                    e_valid = 1'b1;
                    e_char  = top_char;
                    if (slot_free) begin
                        n_count = r_count - CNT_W'(1);
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_PUSH: begin
                if (r_count == CNT_W'(STACK_DEPTH)) begin
                    e_valid = 1'b1;
                    e_err   = ERR_OVERFLOW;
                    if (slot_free) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    ram_we  = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (e_fire) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // command and result payload
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (e_fire) begin
            r_o_char <= e_char;
            r_o_last <= e_last;
            r_o_err  <= e_err;
        end
    end

    assign o_out.valid    = r_o_valid;
    assign o_out.out_char = r_o_char;
    assign o_out.is_last  = r_o_last;
    assign o_out.err_code = r_o_err;

endmodule

`default_nettype wire

// ===== rtl/infix_to_postfix_converter.sv =====
// channel   dir  handshake      payload
// i_in      in   valid/ready    in_char[7:0], end_of_expr
// o_out     out  valid/ready    out_char[7:0], is_last, err_code[1:0]
//
// an operand beat goes straight to the result slot and '(' is pushed; ')' and operators
// fetch and test the top entry, emitting each popped operator, and an operator is pushed
// when it meets a lower-priority entry; the end marker pops every entry; o_out stalls hold it
// each stack step is one registered read of the stack RAM and a test of its data
// synchronous active-low reset empties the stack and the command queue
// a two-entry command queue lets input beats arrive while the back end stalls on o_out
`default_nettype none

module infix_to_postfix_converter
    import i2p_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    i2p_in_if.sink     i_in,
    i2p_out_if.source  o_out
);

    t_cmd front_cmd;
    logic front_valid;
    logic front_ready;
    t_cmd queue_cmd;
    logic queue_valid;
    logic queue_ready;

    // classify incoming characters
    i2p_front u_front (
        .i_in        (i_in),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready)
    );

    // decouple front and back
    i2p_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (front_cmd),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .o_cmd   (queue_cmd),
        .o_valid (queue_valid),
        .i_ready (queue_ready)
    );

    // stack sequencer and result register
    i2p_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_cmd_valid (queue_valid),
        .o_cmd_ready (queue_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ===== rtl/i2p_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module i2p_checker
    import i2p_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_char,
    input wire logic       i_out_last,
    input wire logic [1:0] i_out_err
);

    // a stalled result beat keeps its payload
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_char) && $stable(i_out_last) && $stable(i_out_err))

    // terminator carries no character and no error
    `ASSERT_IMPLY(a_last_clean, i_clk, i_rst_n, i_out_valid && i_out_last, i_out_char == CH_NUL && i_out_err == ERR_NONE)

    // error beats carry no character and never end the expression
    `ASSERT_IMPLY(a_err_clean, i_clk, i_rst_n, i_out_valid && i_out_err != ERR_NONE, i_out_char == CH_NUL && !i_out_last && (i_out_err == ERR_UNMATCHED || i_out_err == ERR_OVERFLOW))

    // empty queue after reset takes input at once
    `ASSERT_IMPLY(a_ready_after_rst, i_clk, i_rst_n, $rose(i_rst_n), i_in_ready)

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.out_char),
    .i_out_last  (o_out.is_last),
    .i_out_err   (o_out.err_code)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import i2p_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 150;

    // one postfix beat as seen on the result channel
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic [1:0]        err;
    } t_postfix_beat;

    // shunting-yard predictor plus queue of postfix beats still owed by the block
    class postfix_scoreboard;
        logic [CHAR_W-1:0] op_stk [STACK_DEPTH];
        int                op_cnt;
        t_postfix_beat     owed_beats [$];
        int                errors;

        function new();
            op_cnt = 0;
            errors = 0;
        endfunction

        function int pending();
            return owed_beats.size();
        endfunction

        function void owe(logic [CHAR_W-1:0] ch, logic last, logic [1:0] err);
            t_postfix_beat b;
            b.ch   = ch;
            b.last = last;
            b.err  = err;
            owed_beats.push_back(b);
        endfunction

        function bit is_operand(logic [CHAR_W-1:0] c);
            return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                   (c >= "a" && c <= "z");
        endfunction

        function int rank_arriving(logic [CHAR_W-1:0] c);
            case (c)
                CH_PLUS, CH_MINUS: return 1;
                CH_STAR, CH_SLASH: return 2;
                CH_CARET:          return 4;
                default:           return 0;
            endcase
        endfunction

        // caret ranks lower once stacked, so a^b^c groups to the right
        function int rank_stacked(logic [CHAR_W-1:0] c);
            case (c)
                CH_PLUS, CH_MINUS: return 1;
                CH_STAR, CH_SLASH: return 2;
                CH_CARET:          return 3;
                default:           return 0;
            endcase
        endfunction

        function void push_op(logic [CHAR_W-1:0] c);
            if (op_cnt >= STACK_DEPTH) begin
                owe(CH_NUL, 1'b0, ERR_OVERFLOW);
            end else begin
                op_stk[op_cnt] = c;
                op_cnt++;
            end
        endfunction

        // accepted input beat: work out the postfix beats it releases
        function void note_char(logic [CHAR_W-1:0] c, logic eoe);
            int  pin;
            bit  found;
            if (eoe) begin
                while (op_cnt > 0) begin
                    op_cnt--;
                    owe(op_stk[op_cnt], 1'b0, ERR_NONE);
                end
                owe(CH_NUL, 1'b1, ERR_NONE);
                return;
            end
            if (is_operand(c)) begin
                owe(c, 1'b0, ERR_NONE);
            end else if (c == CH_LPAREN) begin
                push_op(c);
            end else if (c == CH_RPAREN) begin
                found = 1'b0;
                while (op_cnt > 0 && !found) begin
                    op_cnt--;
                    if (op_stk[op_cnt] == CH_LPAREN) found = 1'b1;
                    else owe(op_stk[op_cnt], 1'b0, ERR_NONE);
                end
                if (!found) owe(CH_NUL, 1'b0, ERR_UNMATCHED);
            end else begin
                pin = rank_arriving(c);
                while (op_cnt > 0 && rank_stacked(op_stk[op_cnt-1]) >= pin) begin
                    op_cnt--;
                    owe(op_stk[op_cnt], 1'b0, ERR_NONE);
                end
                push_op(c);
            end
        endfunction

        // accepted result beat: compare with the oldest owed beat
        function void check_beat(logic [CHAR_W-1:0] ch, logic last, logic [1:0] err);
            t_postfix_beat b;
            if (owed_beats.size() == 0) begin
                $error("unexpected result beat: out_char %0h is_last %0b err_code %0d",
                       ch, last, err);
                errors++;
                return;
            end
            b = owed_beats.pop_front();
            if (ch !== b.ch) begin
                $error("out_char: expected %0h, got %0h", b.ch, ch);
                errors++;
            end
            if (last !== b.last) begin
                $error("is_last: expected %0b, got %0b", b.last, last);
                errors++;
            end
            if (err !== b.err) begin
                $error("err_code: expected %0d, got %0d", b.err, err);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    i2p_in_if  in_if ();
    i2p_out_if out_if ();

    infix_to_postfix_converter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    postfix_scoreboard sb;
    int  items_sent = 0;
    int  hold_req   = 0;
    int  stall_cycles = 0;
    bit  in_calm    = 1'b0;
    bit  out_calm   = 1'b0;

    always #2 i_clk = ~i_clk;

    // offer one input beat, idling first at random, and note it once accepted
    task automatic send_beat(input logic [CHAR_W-1:0] c, input logic eoe);
        if (!in_calm) begin
            while ($urandom_range(0, 99) < 17) begin
                in_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_if.valid       <= 1'b1;
        in_if.in_char     <= c;
        in_if.end_of_expr <= eoe;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_char(c, eoe);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
    endtask

    function automatic logic [CHAR_W-1:0] pick_operand();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10) return CHAR_W'("0" + r);
        if (r < 36) return CHAR_W'("A" + r - 10);
        return CHAR_W'("a" + r - 36);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_operator();
        case ($urandom_range(0, 5))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            default: return CH_CARET;
        endcase
    endfunction

    // random infix expression; ragged ones leave '(' open or close too often
    task automatic send_expr(input bit ragged);
        int terms, depth, opens, closes;
        terms = $urandom_range(1, 5);
        depth = 0;
        for (int k = 0; k < terms; k++) begin
            opens = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            repeat (opens) send_beat(CH_LPAREN, 1'b0);
            depth += opens;
            send_beat(pick_operand(), 1'b0);
            if (depth > 0 && $urandom_range(0, 2) == 0) begin
                closes = $urandom_range(1, depth);
                repeat (closes) send_beat(CH_RPAREN, 1'b0);
                depth -= closes;
            end
            if (k < terms - 1) send_beat(pick_operator(), 1'b0);
        end
        if (!ragged) repeat (depth) send_beat(CH_RPAREN, 1'b0);
        else if ($urandom_range(0, 1)) repeat (depth + $urandom_range(1, 2))
            send_beat(CH_RPAREN, 1'b0);
        send_beat(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    // any byte at all, then end of expression
    task automatic send_noise();
        repeat ($urandom_range(1, 6)) send_beat(CHAR_W'($urandom_range(0, 255)), 1'b0);
        send_beat(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    // deep nesting that can run the operator stack full and past it
    task automatic send_nest();
        repeat ($urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 4)) begin
            if ($urandom_range(0, 4) == 0) send_beat(pick_operator(), 1'b0);
            else send_beat(CH_LPAREN, 1'b0);
        end
        send_beat(pick_operand(), 1'b0);
        send_beat(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    // result side: check accepted beats, then pick ready for the next edge
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_if.ready <= 1'b0;
            end else begin
                if (out_if.valid && out_if.ready)
                    sb.check_beat(out_if.out_char, out_if.is_last, out_if.err_code);
                if (hold_seen != hold_req) begin
                    hold_seen = hold_req;
                    hold_left = HOLD_CYCLES;
                end
                if (hold_left > 0) begin
                    hold_left--;
                    out_if.ready <= 1'b0;
                end else begin
                    out_if.ready <= out_calm || ($urandom_range(0, 99) >= 17);
                end
            end
        end
    end

    // watchdog on cycles with no beat accepted on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // stimulus
    initial begin
        int base;
        int expr_idx;
        sb = new();
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.in_char     <= '0;
        in_if.end_of_expr <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // precedence and right-associative caret
        send_text("a+b*c");
        send_beat(CH_NUL, 1'b1);
        send_text("A^Z^0/9");
        send_beat(8'h5A, 1'b1);
        // close that matches, then one with nothing left to match
        send_text("(z-a))");
        send_beat(8'h00, 1'b1);
        // bytes outside the operand set sweep the stack and are stacked themselves
        send_beat(8'hFF, 1'b0);
        send_text("9");
        send_beat(8'h00, 1'b0);
        send_beat(8'h80, 1'b0);
        send_text("(*");
        // flush leaves a stray '(' on the way out
        send_beat(8'hFF, 1'b1);

        base = items_sent;
        expr_idx = 0;
        while (items_sent - base < RANDOM_ITEMS) begin
            in_calm  = (expr_idx >= 6 && expr_idx < 10);
            out_calm = in_calm;
            if (expr_idx == 4) hold_req++;
            if (expr_idx == 2 || expr_idx == 12) begin
                send_nest();
            end else begin
                case ($urandom_range(0, 9))
                    0, 1:    send_noise();
                    2:       send_expr(1'b1);
                    default: send_expr(1'b0);
                endcase
            end
            expr_idx++;
        end
        in_if.valid <= 1'b0;
        in_calm  = 1'b0;
        out_calm = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/i2p_pkg.sv
rtl/i2p_if.sv
rtl/i2p_ram.sv
rtl/i2p_front.sv
rtl/i2p_cmd_queue.sv
rtl/i2p_back.sv
rtl/infix_to_postfix_converter.sv
rtl/i2p_checker.sv
dv/tb_top.sv
